FILE: src/hrdp_pkg.sv
package hrdp_pkg;

	localparam int MAX_PENDING_DEFAULT = 16;

	localparam logic [7:0] TAG_MASK         = 8'hFC;
	localparam logic [7:0] TAG_USAGE_PAGE   = 8'h04;
	localparam logic [7:0] TAG_USAGE        = 8'h08;
	localparam logic [7:0] TAG_USAGE_MIN    = 8'h18;
	localparam logic [7:0] TAG_LOGICAL_MIN  = 8'h14;
	localparam logic [7:0] TAG_LOGICAL_MAX  = 8'h24;
	localparam logic [7:0] TAG_REPORT_SIZE  = 8'h74;
	localparam logic [7:0] TAG_REPORT_ID    = 8'h84;
	localparam logic [7:0] TAG_REPORT_COUNT = 8'h94;
	localparam logic [7:0] TAG_INPUT        = 8'h80;

	localparam logic [7:0] PAGE_DESKTOP = 8'h01;
	localparam logic [7:0] PAGE_BUTTON  = 8'h09;
	localparam logic [7:0] USAGE_X      = 8'h30;
	localparam logic [7:0] USAGE_Y      = 8'h31;
	localparam logic [7:0] USAGE_WHEEL  = 8'h38;

	localparam logic [1:0] KIND_BUTTONS = 2'd0;
	localparam logic [1:0] KIND_X       = 2'd1;
	localparam logic [1:0] KIND_Y       = 2'd2;
	localparam logic [1:0] KIND_WHEEL   = 2'd3;

	typedef struct packed {
		logic [7:0] desc_byte;
		logic       last_byte;
	} in_req_t;

	typedef struct packed {
		logic [1:0]  field_kind;
		logic        present;
		logic [15:0] field_offset;
		logic [15:0] field_width;
		logic signed [31:0] range_min;
		logic signed [31:0] range_max;
		logic        sign_flag;
		logic        rel_flag;
		logic [7:0]  element_count;
		logic [7:0]  rpt_id;
		logic [13:0] report_bytes;
		logic        last_result;
	} out_req_t;

	// controller -> datapath
	typedef struct packed {
		logic take_byte;   // accept and decode the incoming byte
		logic walk_step;   // examine one pending usage of the current Input item
		logic walk_done;   // finish the Input item
		logic emit;        // load output register with kind emit_kind
		logic [1:0] emit_kind;
		logic clear;       // return decode, global and layout state to reset
	} hrdp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic input_start; // taken byte completed an Input item
		logic walk_last;   // current walk step is the final one
	} hrdp_sts_t;

endpackage

FILE: src/hrdp_stream_if.sv
interface hrdp_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/hid_report_descriptor_parser_unit.sv
// HID report descriptor parser. Feed descriptor bytes one request at a time on
// "in"; mark the final byte with last_byte. A byte that completes an Input
// item holds the input while the usage walk runs over the smaller of the
// queued usage count and the report count (at most MAX_PENDING_USAGES):
// the walk reads one queued usage per cycle from the
// usage RAM. The final byte then yields four layout requests on "out"
// (buttons, X, Y, wheel), one per cycle while the sink is ready; the input
// stays held until the fourth is loaded into the output register, after which
// the decode, global and layout state returns to reset for the next
// descriptor. If X or Y was never found, the boot mouse layout is reported.
module hid_report_descriptor_parser_unit #(
	parameter int MAX_PENDING_USAGES = hrdp_pkg::MAX_PENDING_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	hrdp_stream_if.sink   in,
	hrdp_stream_if.source out
);
	import hrdp_pkg::*;

	hrdp_cmd_t cmd;
	hrdp_sts_t sts;

	// sequence control: byte intake, usage walk, result emission
	hrdp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_last(in.data.last_byte), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.cmd(cmd), .sts(sts)
	);

	// item decode, global state, layout records and result register
	hrdp_dpath #(.MAX_PENDING(MAX_PENDING_USAGES)) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.in_data(in.data), .cmd(cmd), .sts(sts), .out_data(out.data)
	);
endmodule

FILE: src/hrdp_ram.sv
module hrdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/hrdp_ctrl.sv
module hrdp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output hrdp_pkg::hrdp_cmd_t cmd,
	input  hrdp_pkg::hrdp_sts_t sts
);
	import hrdp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic       ovalid_q;
	logic       accept;
	logic       load;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = ovalid_q;
	// output register free or being drained
	assign load      = (state_q == ST_EMIT) && (!ovalid_q || out_ready);

	always_comb begin
		cmd = '0;
		cmd.take_byte = accept;
		cmd.walk_step = (state_q == ST_WALK);
		cmd.walk_done = (state_q == ST_WALK) && sts.walk_last;
		cmd.emit      = load;
		cmd.emit_kind = kind_q;
		cmd.clear     = load && (kind_q == KIND_WHEEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= '0;
			last_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= in_last;
						kind_q <= KIND_BUTTONS;
						if (sts.input_start) begin
							state_q <= ST_WALK;
						end else if (in_last) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_WALK: begin
					if (sts.walk_last) begin
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (load) begin
						kind_q <= kind_q + 2'd1;
						if (kind_q == KIND_WHEEL) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_emit_kind_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(load && kind_q != KIND_WHEEL) |=> (state_q == ST_EMIT))
		else $error("emit sequence broken");
	a_clear_on_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (kind_q == KIND_WHEEL && state_q == ST_EMIT))
		else $error("clear out of order");
endmodule

FILE: src/hrdp_dpath.sv
module hrdp_dpath #(
	parameter int MAX_PENDING = hrdp_pkg::MAX_PENDING_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hrdp_pkg::in_req_t   in_data,
	input  hrdp_pkg::hrdp_cmd_t cmd,
	output hrdp_pkg::hrdp_sts_t sts,
	output hrdp_pkg::out_req_t  out_data
);
	import hrdp_pkg::*;

	localparam int AW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
	localparam int CW = $clog2(MAX_PENDING + 1);

	logic [7:0]  header_q;
	logic [2:0]  expect_q, taken_q;
	logic [31:0] acc_q;
	logic [7:0]  page_q, size_q, count_q, rid_q;
	logic [31:0] lmin_q, lmax_q;
	logic [CW-1:0] pend_q;
	logic [15:0] pos_q;
	logic [15:0] off_q [4];
	logic [15:0] wid_q [4];
	logic [31:0] min_q [4];
	logic [31:0] max_q [4];
	logic [2:0]  flg_q [4];
	logic [7:0]  btn_q;
	logic [31:0] idata_q;
	logic [7:0]  idx_q;
	logic [15:0] woff_q;
	logic [15:0] prod_q;
	out_req_t    out_q;

	// byte decode
	logic        done;
	logic [7:0]  hdr;
	logic [2:0]  nexp;
	logic [31:0] val, v;
	logic [2:0]  ntaken;
	always_comb begin
		nexp   = {1'b0, in_data.desc_byte[1:0]};
		if (nexp == 3'd3) nexp = 3'd4;
		ntaken = taken_q + 3'd1;
		if (expect_q == 3'd0) begin
			hdr  = in_data.desc_byte;
			val  = '0;
			done = (nexp == 3'd0);
		end else begin
			hdr  = header_q;
			val  = acc_q | ({24'd0, in_data.desc_byte} << {taken_q[1:0], 3'd0});
			done = (ntaken >= expect_q);
		end
		v = val;
		if (expect_q == 3'd1 && val[7])  v[31:8]  = '1;
		if (expect_q == 3'd2 && val[15]) v[31:16] = '1;
	end

	logic [7:0] tag;
	logic       do_item, q_push;
	logic [7:0] q_val;
	assign tag     = hdr & TAG_MASK;
	assign do_item = cmd.take_byte && done;
	always_comb begin
		q_push = 1'b0;
		q_val  = v[7:0];
		if (do_item && tag == TAG_USAGE) q_push = 1'b1;
		if (do_item && tag == TAG_USAGE_MIN && page_q == PAGE_BUTTON) begin
			q_push = 1'b1;
			q_val  = 8'd1;
		end
	end
	logic q_we;
	assign q_we = q_push && (pend_q < CW'(MAX_PENDING));
	assign sts.input_start = do_item && (tag == TAG_INPUT);

	// usage walk: the ram read of entry idx is registered, so index leads by one
	logic [7:0]  limit;
	logic [7:0]  u;
	logic [AW-1:0] raddr;
	logic        walk_any, step_ok;
	assign limit = (8'(pend_q) < count_q) ? 8'(pend_q) : count_q;
	assign sts.walk_last = (idx_q + 8'd1 >= limit) || (limit == 8'd0);
	assign walk_any = (limit != 8'd0);
	assign raddr = sts.input_start ? '0 : AW'(idx_q + 8'd1);
	assign step_ok = cmd.walk_step && walk_any;

	hrdp_ram #(.WIDTH(8), .DEPTH(MAX_PENDING)) u_q (
		.clk(clk), .we(q_we), .waddr(pend_q[AW-1:0]), .wdata(q_val),
		.raddr(raddr), .rdata(u)
	);

	logic [1:0] ak;
	logic       ahit;
	always_comb begin
		ak = KIND_X; ahit = 1'b0;
		if (page_q == PAGE_DESKTOP) begin
			priority if (u == USAGE_X && !flg_q[KIND_X][0]) begin ak = KIND_X; ahit = 1'b1; end
			else if (u == USAGE_Y && !flg_q[KIND_Y][0]) begin ak = KIND_Y; ahit = 1'b1; end
			else if (u == USAGE_WHEEL && !flg_q[KIND_WHEEL][0]) begin
				ak = KIND_WHEEL; ahit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0; expect_q <= '0; taken_q <= '0; acc_q <= '0;
			page_q <= '0; size_q <= '0; count_q <= '0; rid_q <= '0;
			lmin_q <= '0; lmax_q <= '0; pend_q <= '0; pos_q <= '0; btn_q <= '0;
			idx_q <= '0; woff_q <= '0; prod_q <= '0; idata_q <= '0;
			for (int k = 0; k < 4; k++) begin
				off_q[k] <= '0; wid_q[k] <= '0; min_q[k] <= '0;
				max_q[k] <= '0; flg_q[k] <= '0;
			end
		end else if (cmd.clear) begin
			header_q <= '0; expect_q <= '0; taken_q <= '0; acc_q <= '0;
			page_q <= '0; size_q <= '0; count_q <= '0; rid_q <= '0;
			lmin_q <= '0; lmax_q <= '0; pend_q <= '0; pos_q <= '0; btn_q <= '0;
			for (int k = 0; k < 4; k++) begin
				off_q[k] <= '0; wid_q[k] <= '0; min_q[k] <= '0;
				max_q[k] <= '0; flg_q[k] <= '0;
			end
		end else begin
			if (cmd.take_byte) begin
				if (expect_q == 3'd0) begin
					header_q <= hdr; taken_q <= '0; acc_q <= '0;
					expect_q <= done ? 3'd0 : nexp;
				end else if (done) begin
					expect_q <= '0; taken_q <= '0; acc_q <= '0;
				end else begin
					taken_q <= ntaken; acc_q <= val;
				end
				if (q_we) pend_q <= pend_q + CW'(1);
				if (do_item) begin
					unique case (tag)
						TAG_USAGE_PAGE: begin page_q <= v[7:0]; pend_q <= '0; end
						TAG_LOGICAL_MIN: lmin_q <= v;
						TAG_LOGICAL_MAX: lmax_q <= v;
						TAG_REPORT_SIZE: size_q <= v[7:0];
						TAG_REPORT_COUNT: count_q <= v[7:0];
						TAG_REPORT_ID: begin rid_q <= v[7:0]; pos_q <= 16'd8; end
						TAG_INPUT: begin
							idata_q <= v; idx_q <= '0; woff_q <= pos_q;
							prod_q <= 16'(size_q * count_q);
						end
						default: ;
					endcase
				end
			end
			if (step_ok) begin
				idx_q  <= idx_q + 8'd1;
				woff_q <= woff_q + 16'(size_q);
				if (ahit) begin
					off_q[ak] <= woff_q; wid_q[ak] <= 16'(size_q);
					min_q[ak] <= lmin_q; max_q[ak] <= lmax_q;
					flg_q[ak] <= {idata_q[2], lmin_q[31], 1'b1};
				end else if (page_q == PAGE_BUTTON && !flg_q[KIND_BUTTONS][0]) begin
					off_q[KIND_BUTTONS] <= pos_q; wid_q[KIND_BUTTONS] <= prod_q;
					min_q[KIND_BUTTONS] <= lmin_q; max_q[KIND_BUTTONS] <= lmax_q;
					flg_q[KIND_BUTTONS] <= 3'b001; btn_q <= count_q;
				end
			end
			if (cmd.walk_done) begin
				pend_q <= '0;
				pos_q  <= pos_q + prod_q;
			end
		end
	end

	// result assembly
	logic        good;
	logic [1:0]  k;
	logic [16:0] rb;
	assign good = flg_q[KIND_X][0] && flg_q[KIND_Y][0];
	assign k    = cmd.emit_kind;
	assign rb   = ({1'b0, pos_q} + 17'd7) >> 3;
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.field_kind  <= k;
			out_q.last_result <= (k == KIND_WHEEL);
			if (good) begin
				out_q.present       <= flg_q[k][0];
				out_q.field_offset  <= off_q[k];
				out_q.field_width   <= wid_q[k];
				out_q.range_min     <= min_q[k];
				out_q.range_max     <= max_q[k];
				out_q.sign_flag     <= (k != KIND_BUTTONS) && flg_q[k][1];
				out_q.rel_flag      <= (k != KIND_BUTTONS) && flg_q[k][2];
				out_q.element_count <= !flg_q[k][0] ? 8'd0 :
					(k == KIND_BUTTONS ? btn_q : 8'd1);
				out_q.rpt_id        <= rid_q;
				out_q.report_bytes  <= rb[13:0];
			end else begin
				out_q.present       <= 1'b1;
				out_q.field_offset  <= {11'd0, k, 3'd0};
				out_q.field_width   <= 16'd8;
				out_q.range_min     <= (k == KIND_BUTTONS) ? 32'sd0 : -32'sd127;
				out_q.range_max     <= (k == KIND_BUTTONS) ? 32'sd255 : 32'sd127;
				out_q.sign_flag     <= (k != KIND_BUTTONS);
				out_q.rel_flag      <= (k != KIND_BUTTONS);
				out_q.element_count <= (k == KIND_BUTTONS) ? 8'd3 : 8'd1;
				out_q.rpt_id        <= 8'd0;
				out_q.report_bytes  <= 14'd3;
			end
		end
	end
	assign out_data = out_q;
endmodule
